[hdl/cascaded_interrupt_controller_assert.svh]
// Assertion macros for the cascaded interrupt controller checker
`ifndef CASCADED_INTERRUPT_CONTROLLER_ASSERT_SVH
`define CASCADED_INTERRUPT_CONTROLLER_ASSERT_SVH
// implication checked on every clock edge outside reset
`define CIC_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
// plain invariant
`define CIC_ASSERT_ALWAYS(label, clk, rst, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (expr)) \
      else $error("assertion failed");
`endif

[hdl/cic_pkg.sv]
//------------------------------------------------------------------------------
// cic_pkg
// Types and constants of the cascaded interrupt controller.
//------------------------------------------------------------------------------
`default_nettype none
package cic_pkg;
   localparam int LINES_PER_CHIP = 8;

   localparam logic [2:0] FUNC_PORT_WR = 3'd0;
   localparam logic [2:0] FUNC_PORT_RD = 3'd1;
   localparam logic [2:0] FUNC_ELCR_WR = 3'd2;
   localparam logic [2:0] FUNC_ELCR_RD = 3'd3;
   localparam logic [2:0] FUNC_SET_LINE = 3'd4;
   localparam logic [2:0] FUNC_ACK = 3'd5;

   localparam logic CSR_ELCR_MASK_MASTER = 1'b0;
   localparam logic CSR_ELCR_MASK_SLAVE = 1'b1;

   localparam logic [7:0] ELCR_MASK_MASTER_RST = 8'hf8;
   localparam logic [7:0] ELCR_MASK_SLAVE_RST = 8'hde;

   typedef struct packed {
      logic [2:0] func;
      logic       chip_sel;
      logic       port_a0;
      logic [7:0] data;
      logic [3:0] irq_line;
      logic       level;
   } req_type;

   typedef struct packed {
      logic [7:0] read_data;
      logic [7:0] vector;
      logic       int_request;
      logic       all_ready;
   } rsp_type;
endpackage
`default_nettype wire

[hdl/cascaded_interrupt_controller.sv]
//------------------------------------------------------------------------------
// cascaded_interrupt_controller
// Master/slave pair of 8-line interrupt controllers, slave on master line 2.
//------------------------------------------------------------------------------
// Usage:
//   req_*  : one bus or line word (port write/read, ELCR write/read, line
//            change, acknowledge) per accepted handshake.
//   rsp_*  : exactly one result word per request word, in order.
//   csr_*  : writes the two ELCR writable-bit masks (index 0 master, 1 slave);
//            the user writes only while the block is idle; the block does not enforce this.
// Latency: the result is registered and valid the cycle after acceptance.
// Throughput: one word per cycle while rsp_ready is high; the whole step
//   (rotating priority encoders for slave then master, state update) is one
//   combinational pass between the request handshake and the result register.
// Reset: all chip state clears, masks return to F8/DE, no result pending.
// Stall: while rsp_ready is low the result register holds; req_ready follows
//   rsp_ready || !rsp_valid, so one new word can still enter an empty slot.
//------------------------------------------------------------------------------
`default_nettype none
module cascaded_interrupt_controller (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  req_valid,
   output logic                 req_ready,
   input  cic_pkg::req_type     req_data,
   output logic                 rsp_valid,
   input  wire                  rsp_ready,
   output cic_pkg::rsp_type     rsp_data,
   input  wire                  csr_valid,
   output logic                 csr_ready,
   input  wire                  csr_index,
   input  wire [7:0]            csr_wdata
);
   localparam int LW = $clog2(cic_pkg::LINES_PER_CHIP);
   typedef logic [cic_pkg::LINES_PER_CHIP-1:0] vec_type;
   typedef logic [LW-1:0] idx_type;

   // mode flag bits
   localparam int MF_SEL_ISR = 0, MF_POLL = 1, MF_SMM = 2, MF_AEOI = 3, MF_ROT = 4;
   localparam int MF_SFNM = 5, MF_ICW4 = 6, MF_SINGLE = 7, MF_READY = 8;
   localparam idx_type CASCADE_LINE = idx_type'(2);

   typedef struct packed {
      vec_type    irr;
      vec_type    last;
      vec_type    imr;
      vec_type    isr;
      idx_type    base;
      logic [4:0] vbase;
      logic [1:0] step;
      logic [8:0] mf;
      vec_type    elcr;
      logic       out;
   } chip_type;

   chip_type         chip_ff [2];
   chip_type         chip_in [2];
   logic [7:0]       emask_ff [2];
   cic_pkg::rsp_type rsp_ff, rsp_in;
   logic             rsp_valid_ff;

   assign req_ready = rsp_ready | ~rsp_valid_ff;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_ff;
   assign csr_ready = 1'b1;

   // rank of first set bit counted from base; LINES_PER_CHIP if none
   function automatic logic [LW:0] rank_of(input idx_type base, input vec_type bits);
      logic [LW:0] r;
      r = (LW+1)'(cic_pkg::LINES_PER_CHIP);
      for (int p = cic_pkg::LINES_PER_CHIP - 1; p >= 0; p--)
         if (bits[idx_type'(p + int'(base))]) r = (LW+1)'(p);
      return r;
   endfunction

   // pending line: valid flag and line number
   function automatic logic [LW:0] pending(input chip_type c, input logic master);
      logic [LW:0] p, cur;
      vec_type s;
      p = rank_of(c.base, c.irr & ~c.imr);
      s = c.isr;
      if (c.mf[MF_SMM]) s = s & ~c.imr;
      if (c.mf[MF_SFNM] && master) s[CASCADE_LINE] = 1'b0;
      cur = rank_of(c.base, s);
      if (!p[LW] && p < cur) return {1'b1, idx_type'(p[LW-1:0] + c.base)};
      return '0;
   endfunction

   function automatic chip_type drive(input chip_type c, input idx_type ln, input logic lv);
      chip_type r;
      r = c;
      if (c.elcr[ln]) r.irr[ln] = lv;
      else if (lv && !c.last[ln]) r.irr[ln] = 1'b1;
      r.last[ln] = lv;
      return r;
   endfunction

   function automatic chip_type take(input chip_type c, input idx_type ln);
      chip_type r;
      r = c;
      if (c.mf[MF_AEOI]) begin
         if (c.mf[MF_ROT]) r.base = ln + idx_type'(1);
      end else begin
         r.isr[ln] = 1'b1;
      end
      if (!c.elcr[ln]) r.irr[ln] = 1'b0;
      return r;
   endfunction

   function automatic chip_type pwrite(input chip_type c, input logic a0, input logic [7:0] d);
      chip_type r;
      logic [LW:0] p;
      idx_type ln;
      r = c;
      p = rank_of(c.base, c.isr);
      ln = idx_type'(p[LW-1:0] + c.base);
      if (!a0) begin
         if (d[4]) begin
            r = '0;
            r.elcr = c.elcr;
            r.step = 2'd1;
            r.mf[MF_ICW4] = d[0];
            r.mf[MF_SINGLE] = d[1];
         end else if (d[3]) begin
            if (d[2]) r.mf[MF_POLL] = 1'b1;
            if (d[1:0] == 2'b10) r.mf[MF_SEL_ISR] = 1'b0;
            else if (d[1:0] == 2'b11) r.mf[MF_SEL_ISR] = 1'b1;
            if (d[6:5] == 2'b10) r.mf[MF_SMM] = 1'b0;
            else if (d[6:5] == 2'b11) r.mf[MF_SMM] = 1'b1;
         end else begin
            case (d[7:5])
               3'd0: r.mf[MF_ROT] = 1'b0;
               3'd4: r.mf[MF_ROT] = 1'b1;
               3'd1, 3'd5: begin
                  if (!p[LW]) begin
                     r.isr[ln] = 1'b0;
                     if (d[7]) r.base = ln + idx_type'(1);
                  end
               end
               3'd3: r.isr[d[LW-1:0]] = 1'b0;
               3'd6: r.base = d[LW-1:0] + idx_type'(1);
               3'd7: begin
                  r.isr[d[LW-1:0]] = 1'b0;
                  r.base = d[LW-1:0] + idx_type'(1);
               end
               default: ;
            endcase
         end
      end else begin
         case (c.step)
            2'd0: r.imr = vec_type'(d);
            2'd1: begin
               r.vbase = d[7:3];
               if (c.mf[MF_SINGLE]) r.step = c.mf[MF_ICW4] ? 2'd3 : 2'd0;
               else r.step = 2'd2;
               if (c.mf[MF_SINGLE] && !c.mf[MF_ICW4]) r.mf[MF_READY] = 1'b1;
            end
            2'd2: begin
               if (c.mf[MF_ICW4]) r.step = 2'd3;
               else begin
                  r.step = 2'd0;
                  r.mf[MF_READY] = 1'b1;
               end
            end
            default: begin
               r.mf[MF_SFNM] = d[4];
               r.mf[MF_AEOI] = d[1];
               r.step = 2'd0;
               r.mf[MF_READY] = 1'b1;
            end
         endcase
      end
      return r;
   endfunction

   // one full step of the pair
   always_comb begin
      cic_pkg::req_type q;
      chip_type c0, c1;
      logic [LW:0] pm, ps;
      logic [7:0] rd, vec;
      q = req_data;
      c0 = chip_ff[0];
      c1 = chip_ff[1];
      rd = '0;
      vec = '0;
      pm = pending(c0, 1'b1);
      ps = pending(c1, 1'b0);
      case (q.func)
         cic_pkg::FUNC_PORT_WR: begin
            if (q.chip_sel) c1 = pwrite(c1, q.port_a0, q.data);
            else c0 = pwrite(c0, q.port_a0, q.data);
         end
         cic_pkg::FUNC_PORT_RD: begin
            if (q.chip_sel) begin
               if (c1.mf[MF_POLL]) begin
                  c1.mf[MF_POLL] = 1'b0;
                  if (ps[LW]) begin
                     c1 = take(c1, ps[LW-1:0]);
                     rd = 8'h80 | 8'(ps[LW-1:0]);
                  end
               end else if (!q.port_a0) rd = 8'(c1.mf[MF_SEL_ISR] ? c1.isr : c1.irr);
               else rd = 8'(c1.imr);
            end else begin
               if (c0.mf[MF_POLL]) begin
                  c0.mf[MF_POLL] = 1'b0;
                  if (pm[LW]) begin
                     c0 = take(c0, pm[LW-1:0]);
                     rd = 8'h80 | 8'(pm[LW-1:0]);
                  end
               end else if (!q.port_a0) rd = 8'(c0.mf[MF_SEL_ISR] ? c0.isr : c0.irr);
               else rd = 8'(c0.imr);
            end
         end
         cic_pkg::FUNC_ELCR_WR: begin
            if (q.chip_sel) c1.elcr = vec_type'(q.data & emask_ff[1]);
            else c0.elcr = vec_type'(q.data & emask_ff[0]);
         end
         cic_pkg::FUNC_ELCR_RD: rd = 8'(q.chip_sel ? c1.elcr : c0.elcr);
         cic_pkg::FUNC_SET_LINE: begin
            if (q.irq_line[3]) c1 = drive(c1, q.irq_line[LW-1:0], q.level);
            else if (q.irq_line[LW-1:0] != CASCADE_LINE)
               c0 = drive(c0, q.irq_line[LW-1:0], q.level);
         end
         cic_pkg::FUNC_ACK: begin
            if (!pm[LW]) vec = {c0.vbase, 3'd7};
            else if (pm[LW-1:0] == CASCADE_LINE) begin
               if (ps[LW]) begin
                  c1 = take(c1, ps[LW-1:0]);
                  vec = {c1.vbase, 3'(ps[LW-1:0])};
               end else vec = {c1.vbase, 3'd7};
               c0 = take(c0, CASCADE_LINE);
            end else begin
               c0 = take(c0, pm[LW-1:0]);
               vec = {c0.vbase, 3'(pm[LW-1:0])};
            end
         end
         default: ;
      endcase
      // output recompute: slave, cascade line, master
      ps = pending(c1, 1'b0);
      c1.out = ps[LW];
      c0 = drive(c0, CASCADE_LINE, c1.out);
      pm = pending(c0, 1'b1);
      c0.out = pm[LW];
      chip_in[0] = c0;
      chip_in[1] = c1;
      rsp_in.read_data = rd;
      rsp_in.vector = vec;
      rsp_in.int_request = c0.out;
      rsp_in.all_ready = c0.mf[MF_READY] & c1.mf[MF_READY];
   end

   // state and result registers
   always_ff @(posedge clock) begin
      if (reset) begin
         chip_ff[0] <= '0;
         chip_ff[1] <= '0;
         emask_ff[0] <= cic_pkg::ELCR_MASK_MASTER_RST;
         emask_ff[1] <= cic_pkg::ELCR_MASK_SLAVE_RST;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_valid) begin
            if (csr_index == cic_pkg::CSR_ELCR_MASK_SLAVE) emask_ff[1] <= csr_wdata;
            else emask_ff[0] <= csr_wdata;
         end
         if (req_valid && req_ready) begin
            chip_ff[0] <= chip_in[0];
            chip_ff[1] <= chip_in[1];
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) rsp_ff <= rsp_in;
   end
endmodule
`default_nettype wire

[hdl/cic_checker.sv]
//------------------------------------------------------------------------------
// cic_checker
// Port-level checks of the cascaded interrupt controller.
//------------------------------------------------------------------------------
`default_nettype none
`include "cascaded_interrupt_controller_assert.svh"
module cic_checker (
   input wire              clock,
   input wire              reset,
   input wire              req_valid,
   input wire              req_ready,
   input wire              rsp_valid,
   input wire              rsp_ready,
   input cic_pkg::rsp_type rsp_data
);
   // a stalled result word holds
   `CIC_ASSERT_IMP(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_data))
   // an accepted request yields a result next cycle
   `CIC_ASSERT_IMP(a_rsp_follows, clock, reset, req_valid && req_ready, rsp_valid)
   // the input is open whenever the output slot is free or drains
   `CIC_ASSERT_ALWAYS(a_ready_open, clock, reset, req_ready == (rsp_ready || !rsp_valid))
   // a result word never carries both a vector and read data
   `CIC_ASSERT_ALWAYS(a_vec_rd, clock, reset, !rsp_valid || rsp_data.vector == 8'd0 || rsp_data.read_data == 8'd0)
endmodule

bind cascaded_interrupt_controller cic_checker u_cic_checker (
   .clock(clock), .reset(reset), .req_valid(req_valid), .req_ready(req_ready),
   .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data)
);
`default_nettype wire
